>>> rtl/srrw_pkg.sv
package srrw_pkg;

  localparam int unsigned WINDOW    = 32;
  localparam int unsigned REF_BITS  = 16;
  localparam int unsigned LEN_BITS  = 11;
  localparam int unsigned SEQ_BITS  = 32;
  localparam int unsigned IDX_BITS  = $clog2(WINDOW);
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [SEQ_BITS-1:0] TIMEOUT_RESET = SEQ_BITS'(1000);

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_FIN      = 3'd1,
    KIND_PEER_RST = 3'd2,
    KIND_OTHER    = 3'd3,
    KIND_TICK     = 3'd4,
    KIND_ABORT    = 3'd5
  } in_kind_e;

  typedef enum logic [2:0] {
    OUT_ACK       = 3'd0,
    OUT_DELIVER   = 3'd1,
    OUT_FINISHED  = 3'd2,
    OUT_PEER_RST  = 3'd3,
    OUT_TIMED_OUT = 3'd4,
    OUT_RST_SENT  = 3'd5
  } out_kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CONN_ID   = 2'd0,
    CFG_START_SEQ = 2'd1,
    CFG_TIMEOUT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_DATA     = 3'd0,
    CMD_FIN      = 3'd1,
    CMD_PEER_RST = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_ABORT    = 3'd4
  } cmd_op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_SYNC,
    B_DRAIN
  } back_state_e;

  typedef struct packed {
    logic [2:0]          kind;
    logic                well_formed;
    logic [SEQ_BITS-1:0] conn_tag;
    logic [SEQ_BITS-1:0] seq_number;
    logic [REF_BITS-1:0] payload_ref;
    logic [LEN_BITS-1:0] payload_len;
  } in_t;

  typedef struct packed {
    logic [2:0]          out_kind;
    logic [SEQ_BITS-1:0] ack_number;
    logic [SEQ_BITS-1:0] deliver_seq;
    logic [REF_BITS-1:0] out_payload_ref;
    logic [LEN_BITS-1:0] out_payload_len;
    logic [SEQ_BITS-1:0] next_seq;
    logic                last;
  } out_t;

  typedef struct packed {
    cmd_op_e             op;
    logic [SEQ_BITS-1:0] seq;
    logic [REF_BITS-1:0] pref;
    logic [LEN_BITS-1:0] plen;
  } cmd_t;

  typedef struct packed {
    logic                    en;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [SEQ_BITS-1:0]     data;
  } cfg_wr_t;

endpackage

>>> rtl/srrw_cmd_fifo.sv
module srrw_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srrw_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output srrw_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import srrw_pkg::*;

  localparam int unsigned PTR_BITS = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(CMD_DEPTH + 1);

  cmd_t                mem_q [CMD_DEPTH];
  logic [PTR_BITS-1:0] wptr_q, wptr_d;
  logic [PTR_BITS-1:0] rptr_q, rptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] r;
    if (p == PTR_BITS'(CMD_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == CNT_BITS'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ptr_inc(wptr_q);
    end
    if (pop_i) begin
      rptr_d = ptr_inc(rptr_q);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/srrw_front.sv
module srrw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srrw_pkg::cfg_wr_t cfg_i,
  input  logic              in_valid_i,
  input  srrw_pkg::in_t     in_req_i,
  input  logic              fifo_full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output srrw_pkg::cmd_t    cmd_o
);
  import srrw_pkg::*;

  logic [SEQ_BITS-1:0] conn_id_q, conn_id_d;
  logic                hdr_ok;
  logic                keep;

  assign in_ready_o = !fifo_full_i;
  assign hdr_ok     = in_req_i.well_formed && (in_req_i.conn_tag == conn_id_q);

  // Stateless filtering: foreign or malformed headers and unused kinds never
  // reach the queue.
  always_comb begin
    keep       = 1'b0;
    cmd_o.op   = CMD_DATA;
    cmd_o.seq  = in_req_i.seq_number;
    cmd_o.pref = in_req_i.payload_ref;
    cmd_o.plen = in_req_i.payload_len;
    unique case (in_req_i.kind)
      KIND_DATA: begin
        keep     = hdr_ok;
        cmd_o.op = CMD_DATA;
      end
      KIND_FIN: begin
        keep     = hdr_ok;
        cmd_o.op = CMD_FIN;
      end
      KIND_PEER_RST: begin
        keep     = hdr_ok;
        cmd_o.op = CMD_PEER_RST;
      end
      KIND_TICK: begin
        keep     = 1'b1;
        cmd_o.op = CMD_TICK;
      end
      KIND_ABORT: begin
        keep     = 1'b1;
        cmd_o.op = CMD_ABORT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_valid_i && in_ready_o && keep;

  always_comb begin
    conn_id_d = conn_id_q;
    if (cfg_i.en && (cfg_i.idx == CFG_CONN_ID)) begin
      conn_id_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_id_q <= '0;
    end else begin
      conn_id_q <= conn_id_d;
    end
  end

endmodule

>>> rtl/srrw_back.sv
module srrw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srrw_pkg::cfg_wr_t cfg_i,
  input  srrw_pkg::cmd_t    head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srrw_pkg::out_t    out_req_o
);
  import srrw_pkg::*;

  back_state_e         state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [SEQ_BITS-1:0] exp_q, exp_d;
  logic [SEQ_BITS-1:0] idle_q, idle_d;
  logic [SEQ_BITS-1:0] timeout_q, timeout_d;
  logic                fin_q, fin_d;
  logic [WINDOW-1:0]   full_q, full_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [REF_BITS-1:0] ref_mem [WINDOW];
  logic [LEN_BITS-1:0] len_mem [WINDOW];
  logic [REF_BITS-1:0] rd_ref_q;
  logic [LEN_BITS-1:0] rd_len_q;
  logic                mem_we;
  logic [IDX_BITS-1:0] rd_addr;

  logic                out_free;
  logic                emit;
  logic [SEQ_BITS-1:0] seq_off;
  logic                in_win;
  logic                old_pkt;
  logic [IDX_BITS-1:0] s_idx;
  logic [IDX_BITS-1:0] e_idx;
  logic [IDX_BITS-1:0] e_next;
  logic                full_after;
  logic [SEQ_BITS-1:0] idle_inc;
  logic                deliver_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign seq_off    = cmd_q.seq - exp_q;
  assign in_win     = seq_off < SEQ_BITS'(WINDOW);
  assign old_pkt    = seq_off >= (SEQ_BITS'(0) - SEQ_BITS'(WINDOW));
  assign s_idx      = cmd_q.seq[IDX_BITS-1:0];
  assign e_idx      = exp_q[IDX_BITS-1:0];
  assign e_next     = e_idx + 1'b1;
  // The slot at the expected position is empty between items, so a drain
  // follows only when this packet fills it.
  assign full_after = full_q[e_idx] || (s_idx == e_idx);
  assign idle_inc   = idle_q + 1'b1;
  assign deliver_last = !full_q[e_next];
  assign pop_o      = (state_q == B_IDLE) && !empty_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        if (fin_q) begin
          state_d = B_IDLE;
        end else if (out_free) begin
          if ((cmd_q.op == CMD_DATA) && in_win && full_after) begin
            state_d = B_SYNC;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      B_SYNC: begin
        state_d = B_DRAIN;
      end
      B_DRAIN: begin
        if (out_free && deliver_last) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Datapath and result formation.
  always_comb begin
    cmd_d     = cmd_q;
    exp_d     = exp_q;
    idle_d    = idle_q;
    timeout_d = timeout_q;
    fin_d     = fin_q;
    full_d    = full_q;
    mem_we    = 1'b0;
    emit      = 1'b0;
    out_d     = '0;
    out_d.next_seq = exp_q;

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          cmd_d = head_i;
        end
      end
      B_EXEC: begin
        if (!fin_q && out_free) begin
          unique case (cmd_q.op)
            CMD_TICK: begin
              idle_d = idle_inc;
              if (idle_inc >= timeout_q) begin
                fin_d          = 1'b1;
                emit           = 1'b1;
                out_d.out_kind = OUT_TIMED_OUT;
                out_d.last     = 1'b1;
              end
            end
            CMD_ABORT: begin
              fin_d          = 1'b1;
              emit           = 1'b1;
              out_d.out_kind = OUT_RST_SENT;
              out_d.last     = 1'b1;
            end
            CMD_FIN: begin
              fin_d          = 1'b1;
              emit           = 1'b1;
              out_d.out_kind = OUT_FINISHED;
              out_d.last     = 1'b1;
            end
            CMD_PEER_RST: begin
              fin_d          = 1'b1;
              emit           = 1'b1;
              out_d.out_kind = OUT_PEER_RST;
              out_d.last     = 1'b1;
            end
            CMD_DATA: begin
              if (in_win || old_pkt) begin
                idle_d           = '0;
                emit             = 1'b1;
                out_d.out_kind   = OUT_ACK;
                out_d.ack_number = cmd_q.seq + 1'b1;
                out_d.last       = !(in_win && full_after);
                if (in_win && !full_q[s_idx]) begin
                  full_d[s_idx] = 1'b1;
                  mem_we        = 1'b1;
                end
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      B_SYNC: begin
        emit = 1'b0;
      end
      B_DRAIN: begin
        if (out_free) begin
          full_d[e_idx]         = 1'b0;
          exp_d                 = exp_q + 1'b1;
          emit                  = 1'b1;
          out_d.out_kind        = OUT_DELIVER;
          out_d.deliver_seq     = exp_q;
          out_d.out_payload_ref = rd_ref_q;
          out_d.out_payload_len = rd_len_q;
          out_d.next_seq        = exp_q + 1'b1;
          out_d.last            = deliver_last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    if (cfg_i.en && (cfg_i.idx == CFG_START_SEQ)) begin
      exp_d  = cfg_i.data;
      full_d = '0;
    end
    if (cfg_i.en && (cfg_i.idx == CFG_TIMEOUT)) begin
      timeout_d = cfg_i.data;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // The read port always follows the next expected slot, so the drain sees
  // one registered entry per cycle while the output register is free.
  assign rd_addr = exp_d[IDX_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ref_mem[s_idx] <= cmd_q.pref;
      len_mem[s_idx] <= cmd_q.plen;
    end
    rd_ref_q <= ref_mem[rd_addr];
    rd_len_q <= len_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      exp_q       <= '0;
      idle_q      <= '0;
      timeout_q   <= TIMEOUT_RESET;
      fin_q       <= 1'b0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      idle_q      <= idle_d;
      timeout_q   <= timeout_d;
      fin_q       <= fin_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> rtl/selective_repeat_receive_window.sv
// Receive side of a selective-repeat transfer. Requests on the input channel
// are packet headers, timer ticks and local aborts; requests on the output
// channel are acks, in-order payload deliveries and one final status.
// The front stage accepts one request per cycle into a two-entry command
// queue while the queue is not full, dropping malformed, foreign and unused
// kinds on the spot. The back stage pops one command into a register, then
// acts on it in its execute state. An in-window data packet that completes
// the expected slot passes a sync state for the window RAM read and then
// gives one delivery per cycle while the output register is free; the last
// result of a request has last set. A request therefore passes the idle and
// execute states, and for a release also the sync and drain states, in the
// back stage. The output register is reloaded in the cycle its result is
// taken, so results can leave back to back; a stalled receiver stalls the
// back stage, then the queue, then in_ready_o. Configuration writes are
// registered; a write of start_seq also clears every window mark. Reset
// clears the window marks, sets the expected sequence and connection id to
// zero and the timeout to 1000 ticks. After fin, peer reset, timeout or abort
// every request is swallowed until reset.
module selective_repeat_receive_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srrw_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [srrw_pkg::SEQ_BITS-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  srrw_pkg::in_t                       in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output srrw_pkg::out_t                      out_req_o
);
  import srrw_pkg::*;

  cfg_wr_t cfg;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;
  logic    fifo_full;
  logic    fifo_empty;

  assign cfg.en   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  srrw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .fifo_full_i (fifo_full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  srrw_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (fifo_full),
    .empty_o    (fifo_empty)
  );

  srrw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_i      (head),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import srrw_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_PRINTS    = 30;
  localparam int unsigned HOLD_CYCLES   = 300;
  // Offsets at or above this edge lie behind the window.
  localparam logic [SEQ_BITS-1:0] OLD_EDGE = ~(SEQ_BITS'(WINDOW) - 1);

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i   = '0;
  logic [SEQ_BITS-1:0]     cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  in_t                     in_req_i    = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  out_t                    out_req_o;

  // Register copies and window state as the receiver should hold them.
  logic [SEQ_BITS-1:0] cfg_conn    = '0;
  logic [SEQ_BITS-1:0] cfg_timeout = TIMEOUT_RESET;
  logic [SEQ_BITS-1:0] exp_seq     = '0;
  logic [WINDOW-1:0]   slot_held   = '0;
  logic [REF_BITS-1:0] slot_ref [WINDOW];
  logic [LEN_BITS-1:0] slot_len [WINDOW];
  logic [SEQ_BITS-1:0] idle_ticks  = '0;
  logic                xfer_done   = 1'b0;
  out_t                owed_results [$];

  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 19;
  int unsigned recv_gap_pct = 78;
  int unsigned hold_left    = 0;

  selective_repeat_receive_window dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("tb_top: mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic void push_result(out_kind_e kind, logic [SEQ_BITS-1:0] ack,
                                      logic [SEQ_BITS-1:0] dseq,
                                      logic [REF_BITS-1:0] pref,
                                      logic [LEN_BITS-1:0] plen);
    out_t r;
    r.out_kind        = kind;
    r.ack_number      = ack;
    r.deliver_seq     = dseq;
    r.out_payload_ref = pref;
    r.out_payload_len = plen;
    r.next_seq        = exp_seq;
    r.last            = 1'b0;
    owed_results.push_back(r);
  endfunction

  function automatic void window_step(in_t req);
    int unsigned         first;
    int unsigned         drained;
    logic [SEQ_BITS-1:0] seq_off;
    logic [IDX_BITS-1:0] s;
    logic [IDX_BITS-1:0] e;
    out_t                r;
    first   = owed_results.size();
    drained = 0;
    if (!xfer_done) begin
      case (req.kind)
        KIND_TICK: begin
          idle_ticks++;
          if (idle_ticks >= cfg_timeout) begin
            xfer_done = 1'b1;
            push_result(OUT_TIMED_OUT, '0, '0, '0, '0);
          end
        end
        KIND_ABORT: begin
          xfer_done = 1'b1;
          push_result(OUT_RST_SENT, '0, '0, '0, '0);
        end
        KIND_DATA, KIND_FIN, KIND_PEER_RST: begin
          if (req.well_formed && req.conn_tag == cfg_conn) begin
            if (req.kind == KIND_FIN) begin
              xfer_done = 1'b1;
              push_result(OUT_FINISHED, '0, '0, '0, '0);
            end else if (req.kind == KIND_PEER_RST) begin
              xfer_done = 1'b1;
              push_result(OUT_PEER_RST, '0, '0, '0, '0);
            end else begin
              seq_off = req.seq_number - exp_seq;
              if (seq_off < WINDOW || seq_off >= OLD_EDGE) begin
                idle_ticks = '0;
                push_result(OUT_ACK, req.seq_number + 1'b1, '0, '0, '0);
                if (seq_off < WINDOW) begin
                  s = req.seq_number[IDX_BITS-1:0];
                  if (!slot_held[s]) begin
                    slot_held[s] = 1'b1;
                    slot_ref[s]  = req.payload_ref;
                    slot_len[s]  = req.payload_len;
                  end
                  while (drained < WINDOW && slot_held[exp_seq[IDX_BITS-1:0]]) begin
                    e = exp_seq[IDX_BITS-1:0];
                    slot_held[e] = 1'b0;
                    exp_seq++;
                    push_result(OUT_DELIVER, '0, exp_seq - 1'b1, slot_ref[e], slot_len[e]);
                    drained++;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (owed_results.size() > first) begin
      r = owed_results.pop_back();
      r.last = 1'b1;
      owed_results.push_back(r);
    end
  endfunction

  task automatic check_field(string name, logic [SEQ_BITS-1:0] got,
                             logic [SEQ_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    end
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result of kind %0d with nothing owed", got.out_kind));
    end else begin
      want = owed_results.pop_front();
      check_field("out_kind", SEQ_BITS'(got.out_kind), SEQ_BITS'(want.out_kind));
      check_field("ack_number", got.ack_number, want.ack_number);
      check_field("deliver_seq", got.deliver_seq, want.deliver_seq);
      check_field("out_payload_ref", SEQ_BITS'(got.out_payload_ref),
                  SEQ_BITS'(want.out_payload_ref));
      check_field("out_payload_len", SEQ_BITS'(got.out_payload_len),
                  SEQ_BITS'(want.out_payload_len));
      check_field("next_seq", got.next_seq, want.next_seq);
      check_field("last", SEQ_BITS'(got.last), SEQ_BITS'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        window_step(in_req_i);
      end
      if (out_valid_o && out_ready_i) begin
        check_result(out_req_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: watchdog expired after %0d cycles without a request", QUIET_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side: a long hold-off when one is pending, else random stalls.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_gap_pct);
    end
  end

  // All driving tasks start and return just after a falling edge, so the
  // window state is settled when the next request is built.
  task automatic send_request(in_t req);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SEQ_BITS-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_CONN_ID: cfg_conn = val;
      CFG_START_SEQ: begin
        exp_seq   = val;
        slot_held = '0;
      end
      CFG_TIMEOUT: cfg_timeout = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_t make_item(logic [2:0] kind, logic wf, logic [SEQ_BITS-1:0] tag,
                                    logic [SEQ_BITS-1:0] seq);
    in_t req;
    req.kind        = kind;
    req.well_formed = wf;
    req.conn_tag    = tag;
    req.seq_number  = seq;
    req.payload_ref = REF_BITS'($urandom);
    req.payload_len = LEN_BITS'($urandom);
    return req;
  endfunction

  // Mostly packets of this connection around the window, with ticks and
  // malformed, foreign and unused headers mixed in. Never a finishing request.
  function automatic in_t traffic_item();
    in_t         req;
    int unsigned pick;
    req  = make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq);
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      req.seq_number = exp_seq;
    end else if (pick < 40) begin
      req.seq_number = exp_seq + $urandom_range(7, 0);
    end else if (pick < 52) begin
      req.seq_number = exp_seq + $urandom_range(WINDOW - 1, 0);
    end else if (pick < 58) begin
      req.seq_number = exp_seq - $urandom_range(WINDOW, 1);
    end else if (pick < 62) begin
      req.seq_number = exp_seq + $urandom_range(OLD_EDGE - 1, WINDOW);
    end else if (pick < 64) begin
      req.seq_number = $urandom;
    end else if (pick < 74) begin
      req = make_item(KIND_TICK, 1'($urandom), $urandom, $urandom);
    end else if (pick < 82) begin
      req.kind        = 3'($urandom_range(KIND_OTHER, KIND_DATA));
      req.well_formed = 1'b0;
    end else if (pick < 90) begin
      req.kind     = 3'($urandom_range(KIND_OTHER, KIND_DATA));
      req.conn_tag = cfg_conn ^ ($urandom | (32'h1 << $urandom_range(31, 0)));
    end else if (pick < 95) begin
      req.kind = KIND_OTHER;
    end else begin
      req = make_item(3'($urandom_range(7, 6)), 1'($urandom), $urandom, $urandom);
    end
    return req;
  endfunction

  task automatic run_traffic(int unsigned send_pct, int unsigned recv_pct,
                             int unsigned count);
    in_t         req;
    int unsigned n;
    n            = 0;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    while (n < count) begin
      req = traffic_item();
      send_request(req);
      if (req.kind == KIND_TICK ||
          (req.kind == KIND_DATA && req.well_formed && req.conn_tag == cfg_conn)) begin
        n++;
      end
    end
    settle();
  endtask

  task automatic test_reset_state();
    send_request(make_item(KIND_DATA, 1'b1, '0, '0));
    send_request(make_item(KIND_TICK, 1'b1, '0, '0));
    settle();
  endtask

  task automatic test_directed();
    in_t req;
    write_reg(CFG_CONN_ID, $urandom);
    write_reg(CFG_START_SEQ, 32'hFFFF_FFF0);
    // A duplicate of a held slot is acknowledged but must not replace it.
    req = make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq + 1);
    req.payload_ref = '1;
    req.payload_len = '1;
    send_request(req);
    req.payload_ref = '0;
    req.payload_len = '0;
    send_request(req);
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq));
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq - 1));
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq - WINDOW));
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq - WINDOW - 1));
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq + WINDOW));
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq + WINDOW - 1));
    // The ack of the top sequence number wraps to zero.
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, '1));
    send_request(make_item(KIND_DATA, 1'b0, cfg_conn, exp_seq));
    send_request(make_item(KIND_DATA, 1'b1, ~cfg_conn, exp_seq));
    send_request(make_item(KIND_FIN, 1'b0, cfg_conn, '0));
    send_request(make_item(KIND_PEER_RST, 1'b1, ~cfg_conn, '0));
    send_request(make_item(KIND_OTHER, 1'b1, cfg_conn, exp_seq));
    send_request(make_item(3'd6, 1'b1, cfg_conn, exp_seq));
    send_request(make_item(3'd7, 1'b1, cfg_conn, exp_seq));
    send_request(make_item(KIND_TICK, 1'b0, ~cfg_conn, '1));
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq));
    settle();
  endtask

  // Fill every slot ahead of the expected one, then close the gap so that one
  // request releases the whole window across the sequence wrap.
  task automatic test_full_drain();
    int k;
    write_reg(CFG_START_SEQ, '1);
    for (k = WINDOW - 1; k >= 0; k--) begin
      send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq + k));
    end
    settle();
  endtask

  task automatic test_traffic_phases();
    write_reg(CFG_CONN_ID, '1);
    write_reg(CFG_START_SEQ, $urandom);
    write_reg(CFG_TIMEOUT, '1);
    run_traffic(19, 78, 40);
    write_reg(CFG_CONN_ID, '0);
    write_reg(CFG_START_SEQ, '0);
    write_reg(CFG_TIMEOUT, $urandom_range(32'hFFFF_FFFE, 32'h0001_0000));
    run_traffic(78, 19, 40);
    write_reg(CFG_CONN_ID, $urandom);
    write_reg(CFG_START_SEQ, 32'hFFFF_FFE8);
    run_traffic(0, 0, 40);
  endtask

  // The result side holds off while in-order data keeps coming, so the
  // block fills and has to stall its input.
  task automatic test_backpressure();
    int k;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_left    = HOLD_CYCLES;
    for (k = 0; k < 24; k++) begin
      send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq));
    end
    settle();
  endtask

  // Only one way to finish fits in a run; the rest are ignored afterwards.
  task automatic test_finish();
    int unsigned way;
    way = $urandom_range(3, 0);
    case (way)
      0: send_request(make_item(KIND_FIN, 1'b1, cfg_conn, $urandom));
      1: send_request(make_item(KIND_PEER_RST, 1'b1, cfg_conn, $urandom));
      2: send_request(make_item(KIND_ABORT, 1'b0, ~cfg_conn, $urandom));
      default: begin
        write_reg(CFG_TIMEOUT, $urandom_range(5, 0));
        while (!xfer_done) begin
          send_request(make_item(KIND_TICK, 1'($urandom), $urandom, $urandom));
        end
      end
    endcase
    send_request(make_item(KIND_DATA, 1'b1, cfg_conn, exp_seq));
    send_request(make_item(KIND_FIN, 1'b1, cfg_conn, '0));
    send_request(make_item(KIND_TICK, 1'b1, cfg_conn, '0));
    send_request(make_item(KIND_ABORT, 1'b1, cfg_conn, '0));
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_directed();
    test_full_drain();
    test_traffic_phases();
    test_backpressure();
    test_finish();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/srrw_pkg.sv
rtl/srrw_cmd_fifo.sv
rtl/srrw_front.sv
rtl/srrw_back.sv
rtl/selective_repeat_receive_window.sv
tb/tb_top.sv
